FILE: src/cubic_bezier_tessellator_unit_assert.svh
// ----------------------------------------------------------------------------
// Cubic Bezier tessellator assertion macros
// Shared property forms for the concurrent checks of the tessellator.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_TESSELLATOR_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_TESSELLATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cbt_pkg.sv
// ----------------------------------------------------------------------------
// Cubic Bezier tessellator package
// Widths, types and lane control shared by the tessellator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cbt_pkg;

    localparam int COORD_BITS     = 32;
    localparam int ACC_BITS       = 56;
    localparam int EXTRA_BITS     = ACC_BITS - COORD_BITS - 8;
    localparam int SUB_BITS       = 6;
    localparam int DEN_BITS       = 3 * SUB_BITS;
    localparam int COEF_BITS      = COORD_BITS + 4;
    localparam int NUM_BITS       = COEF_BITS + 2 * SUB_BITS + 1;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DVD_BITS       = ((NUM_BITS + EXTRA_BITS + 1 + DIV_RADIX_BITS - 1)
                                     / DIV_RADIX_BITS) * DIV_RADIX_BITS;
    localparam int DIV_STEPS      = DVD_BITS / DIV_RADIX_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
    localparam int SETUP_LAT      = 4;
    localparam int SETUP_CNT_BITS = $clog2(SETUP_LAT + 1);
    localparam int NUM_LANES      = 2;
    localparam int NUM_CTRL       = 4;
    localparam int NUM_DIFFS      = 3;

    localparam logic [SUB_BITS-1:0] SUB_RESET = SUB_BITS'(16);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [ACC_BITS-1:0]          t_acc;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic acc_load;
        logic acc_step;
    } t_lane_ctl;

endpackage

`default_nettype wire

FILE: src/cubic_bezier_tessellator_unit.sv
// ----------------------------------------------------------------------------
// Cubic Bezier tessellator
// Turns one cubic segment per input beat into N+1 points by forward
// differencing, with one lane for x and one for y.
//
//   Channel | Handshake                | Payload
//   config  | i_cfg_wr_en              | i_cfg_wr_data (subdivisions)
//   segment | i_in_valid / o_in_stall  | start, handles and end in x and y
//   point   | o_out_valid / i_out_stall| point x/y, index, last flag
//
// The setup phase forms the difference numerators in registered stages, the
// shared-step dividers retire four quotient bits per step, then one point
// leaves per cycle while the output is not stalled.
// Reset is synchronous and sets N to 16; no clearing pass is needed.
// Output stalls hold the point register and pause stepping.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cubic_bezier_tessellator_unit_assert.svh"

module cubic_bezier_tessellator_unit import cbt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [SUB_BITS-1:0] i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_coord              i_start_x,
    input  wire t_coord              i_handle_out_x,
    input  wire t_coord              i_handle_in_x,
    input  wire t_coord              i_end_x,
    input  wire t_coord              i_start_y,
    input  wire t_coord              i_handle_out_y,
    input  wire t_coord              i_handle_in_y,
    input  wire t_coord              i_end_y,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_coord                   o_point_x,
    output t_coord                   o_point_y,
    output logic [SUB_BITS-1:0]      o_point_index,
    output logic                     o_last_point
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                    r_state;
    logic [SUB_BITS-1:0]       r_subdiv;
    logic [SUB_BITS-1:0]       r_n;
    logic [SETUP_CNT_BITS-1:0] r_cnt;
    logic [SUB_BITS-1:0]       r_step;
    logic                      r_out_valid;
    t_coord                    r_point_x;
    t_coord                    r_point_y;
    logic [SUB_BITS-1:0]       r_point_index;
    logic                      r_last;

    t_lane_ctl           lane_ctl;
    logic                in_accept;
    logic                emit;
    logic                last_step;
    logic                lane_done;
    logic [SUB_BITS-1:0] n_eff;
    t_coord              w_k [NUM_LANES][NUM_CTRL];
    t_coord              w_point [NUM_LANES];
    logic [NUM_LANES-1:0] w_done;

    assign w_k[0][0] = i_start_x;
    assign w_k[0][1] = i_handle_out_x;
    assign w_k[0][2] = i_handle_in_x;
    assign w_k[0][3] = i_end_x;
    assign w_k[1][0] = i_start_y;
    assign w_k[1][1] = i_handle_out_y;
    assign w_k[1][2] = i_handle_in_y;
    assign w_k[1][3] = i_end_y;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign emit      = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign last_step = (r_step == r_n);
    assign lane_done = &w_done;
    assign n_eff     = (r_subdiv == '0) ? SUB_BITS'(1) : r_subdiv;

    assign lane_ctl.capture   = in_accept;
    assign lane_ctl.div_start = (r_state == S_SETUP) &&
                                (r_cnt == SETUP_CNT_BITS'(SETUP_LAT));
    assign lane_ctl.acc_load  = (r_state == S_DIV) && lane_done;
    assign lane_ctl.acc_step  = emit;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        cbt_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_n     (r_n),
            .i_k0    (w_k[l][0]),
            .i_k1    (w_k[l][1]),
            .i_k2    (w_k[l][2]),
            .i_k3    (w_k[l][3]),
            .o_point (w_point[l]),
            .o_done  (w_done[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_subdiv    <= SUB_RESET;
            r_n         <= SUB_BITS'(1);
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_subdiv <= i_cfg_wr_data;
            end
            if (emit) begin
                r_out_valid   <= 1'b1;
                r_point_x     <= w_point[0];
                r_point_y     <= w_point[1];
                r_point_index <= r_step;
                r_last        <= last_step;
                r_step        <= r_step + SUB_BITS'(1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_n     <= n_eff;
                        r_cnt   <= '0;
                        r_step  <= '0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_cnt <= r_cnt + SETUP_CNT_BITS'(1);
                    if (lane_ctl.div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (lane_ctl.acc_load) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit && last_step) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_point_x     = r_point_x;
    assign o_point_y     = r_point_y;
    assign o_point_index = r_point_index;
    assign o_last_point  = r_last;

    `CBT_ASSERT_NEXT(a_index_steps, o_out_valid && !i_out_stall && !o_last_point, o_out_valid && (o_point_index == $past(o_point_index) + SUB_BITS'(1)), "point index did not advance by one")
    `CBT_ASSERT_SAME(a_done_in_div, lane_done, r_state == S_DIV, "divider finished outside the divide phase")
    `CBT_ASSERT_NEXT(a_empty_after_last, o_out_valid && !i_out_stall && o_last_point, !o_out_valid, "point shown after the last point of a segment")

endmodule

`default_nettype wire

FILE: src/cbt_div.sv
// ----------------------------------------------------------------------------
// Cubic Bezier tessellator divider
// Unsigned restoring divider that retires several quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_div import cbt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DVD_BITS-1:0] i_dividend,
    input  wire logic [DEN_BITS-1:0] i_divisor,
    output logic                     o_done,
    output logic [DVD_BITS-1:0]      o_quotient
);

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DVD_BITS-1:0]     r_quo;
    logic [DEN_BITS-1:0]     r_rem;
    logic [DEN_BITS-1:0]     r_den;
    logic [DVD_BITS-1:0]     n_quo;
    logic [DEN_BITS-1:0]     n_rem;

    always_comb begin
        logic [DEN_BITS:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int j = 0; j < DIV_RADIX_BITS; j++) begin
            trial = {n_rem, n_quo[DVD_BITS-1]};
            n_quo = {n_quo[DVD_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial    = trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_BITS'(1);
                if (r_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

FILE: src/cbt_lane.sv
// ----------------------------------------------------------------------------
// Cubic Bezier tessellator axis lane
// Forms the forward differences of one axis and steps its accumulators.
// ----------------------------------------------------------------------------
`default_nettype none

module cbt_lane import cbt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_lane_ctl           i_ctl,
    input  wire logic [SUB_BITS-1:0] i_n,
    input  wire t_coord              i_k0,
    input  wire t_coord              i_k1,
    input  wire t_coord              i_k2,
    input  wire t_coord              i_k3,
    output t_coord                   o_point,
    output logic                     o_done
);

    t_coord r_k0;
    t_coord r_k1;
    t_coord r_k2;
    t_coord r_k3;

    logic signed [COEF_BITS-1:0]  r_a;
    logic signed [COEF_BITS-1:0]  r_b;
    logic signed [COEF_BITS-1:0]  r_c;
    logic [2*SUB_BITS-1:0]        r_n2;
    logic signed [COEF_BITS+SUB_BITS:0] r_bn;
    logic signed [NUM_BITS-1:0]   r_cn2;
    logic signed [COEF_BITS+2:0]  r_a6;
    logic [DEN_BITS-1:0]          r_den;
    logic signed [NUM_BITS-1:0]   r_num [NUM_DIFFS];
    logic [DVD_BITS-1:0]          r_dvd [NUM_DIFFS];
    logic                         r_neg [NUM_DIFFS];

    t_acc r_pos;
    t_acc r_d1;
    t_acc r_d2;
    t_acc r_d3;

    logic signed [COEF_BITS-1:0]      k0e, k1e, k2e, k3e;
    logic signed [COEF_BITS-1:0]      d10, d12, s2, a, b, c;
    logic signed [SUB_BITS:0]         n_s;
    logic signed [2*SUB_BITS:0]       n2_s;
    logic signed [COEF_BITS+SUB_BITS:0] bn;
    logic signed [NUM_BITS-1:0]       cn2;
    logic signed [COEF_BITS+2:0]      ax, a6;
    logic [NUM_BITS-1:0]              mag [NUM_DIFFS];
    logic [DVD_BITS-1:0]              w_quo [NUM_DIFFS];
    logic [NUM_DIFFS-1:0]             w_done;
    t_acc                             diff [NUM_DIFFS];
    t_acc                             pos_init;

    always_comb begin
        k0e  = COEF_BITS'(r_k0);
        k1e  = COEF_BITS'(r_k1);
        k2e  = COEF_BITS'(r_k2);
        k3e  = COEF_BITS'(r_k3);
        d10  = k1e - k0e;
        d12  = k1e - k2e;
        s2   = k0e - (k1e <<< 1) + k2e;
        c    = (d10 <<< 1) + d10;
        b    = (s2 <<< 1) + s2;
        a    = k3e - k0e + (d12 <<< 1) + d12;
        n_s  = signed'({1'b0, i_n});
        n2_s = signed'({1'b0, r_n2});
        bn   = r_b * n_s;
        cn2  = r_c * n2_s;
        ax   = (COEF_BITS + 3)'(r_a);
        a6   = (ax <<< 2) + (ax <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_k0 <= i_k0;
            r_k1 <= i_k1;
            r_k2 <= i_k2;
            r_k3 <= i_k3;
        end
        r_a      <= a;
        r_b      <= b;
        r_c      <= c;
        r_n2     <= i_n * i_n;
        r_bn     <= bn;
        r_cn2    <= cn2;
        r_a6     <= a6;
        r_den    <= r_n2 * i_n;
        r_num[0] <= NUM_BITS'(r_a) + NUM_BITS'(r_bn) + r_cn2;
        r_num[1] <= NUM_BITS'(r_a6) + (NUM_BITS'(r_bn) <<< 1);
        r_num[2] <= NUM_BITS'(r_a6);
    end

    for (genvar m = 0; m < NUM_DIFFS; m++) begin : g_diff
        assign mag[m] = r_num[m][NUM_BITS-1] ? NUM_BITS'(-r_num[m]) : NUM_BITS'(r_num[m]);

        always_ff @(posedge i_clk) begin
            r_neg[m] <= r_num[m][NUM_BITS-1];
            r_dvd[m] <= DVD_BITS'({mag[m], {EXTRA_BITS{1'b0}}}) + DVD_BITS'(r_den >> 1);
        end

        cbt_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (i_ctl.div_start),
            .i_dividend (r_dvd[m]),
            .i_divisor  (r_den),
            .o_done     (w_done[m]),
            .o_quotient (w_quo[m])
        );

        assign diff[m] = r_neg[m] ? (t_acc'(0) - w_quo[m][ACC_BITS-1:0])
                                  : w_quo[m][ACC_BITS-1:0];
    end

    assign pos_init = {{(ACC_BITS - EXTRA_BITS - COORD_BITS){r_k0[COORD_BITS-1]}},
                       r_k0, {EXTRA_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_load) begin
            r_pos <= pos_init;
            r_d1  <= diff[0];
            r_d2  <= diff[1];
            r_d3  <= diff[2];
        end else if (i_ctl.acc_step) begin
            r_pos <= r_pos + r_d1;
            r_d1  <= r_d1 + r_d2;
            r_d2  <= r_d2 + r_d3;
        end
    end

    assign o_point = r_pos[EXTRA_BITS +: COORD_BITS];
    assign o_done  = &w_done;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Cubic Bezier tessellator testbench
// Sends cubic segments through the tessellator under random input gaps and
// output stalls. A forward-differencing predictor, run at the configured
// subdivision count, queues the expected points of each segment. Every point
// beat is checked against the oldest queued point.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cbt_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    localparam t_coord COORD_MAX = 32'sh7fff_ffff;
    localparam t_coord COORD_MIN = 32'sh8000_0000;
    localparam t_coord ONE       = 32'sh0001_0000;

    typedef struct {
        t_coord x[4];
        t_coord y[4];
    } t_segment;

    typedef struct packed {
        t_coord              x;
        t_coord              y;
        logic [SUB_BITS-1:0] idx;
        logic                last;
    } t_point;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} t_stall_mode;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [SUB_BITS-1:0] cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    t_coord              start_x, handle_out_x, handle_in_x, end_x;
    t_coord              start_y, handle_out_y, handle_in_y, end_y;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_coord              point_x, point_y;
    logic [SUB_BITS-1:0] point_index;
    logic                last_point;

    t_point              pending_points[$];
    logic [SUB_BITS-1:0] subdiv_cfg = SUB_RESET;
    int                  mismatch_count = 0;
    int                  burst_left = 0;
    t_stall_mode         stall_mode = STALL_NONE;
    int                  stall_run = 0;

    cubic_bezier_tessellator_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_start_x      (start_x),
        .i_handle_out_x (handle_out_x),
        .i_handle_in_x  (handle_in_x),
        .i_end_x        (end_x),
        .i_start_y      (start_y),
        .i_handle_out_y (handle_out_y),
        .i_handle_in_y  (handle_in_y),
        .i_end_y        (end_y),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_point_x      (point_x),
        .o_point_y      (point_y),
        .o_point_index  (point_index),
        .o_last_point   (last_point)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Rounds num * 2^EXTRA_BITS / den to the nearest accumulator step, ties away
    // from zero, and returns the accumulator bit pattern.
    function automatic t_acc scaled_quotient(input longint num, input longint unsigned den);
        logic              neg;
        longint unsigned   mag;
        longint unsigned   q;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        mag = mag << EXTRA_BITS;
        q = (mag + den / 2) / den;
        return neg ? t_acc'(-q) : t_acc'(q);
    endfunction

    function automatic void setup_lane(input t_coord k0_w, input t_coord k1_w,
                                       input t_coord k2_w, input t_coord k3_w,
                                       input longint unsigned n,
                                       output t_acc pos, output t_acc d1,
                                       output t_acc d2, output t_acc d3);
        longint          k0, k1, k2, k3, nn, ca, cb, cc;
        longint unsigned den;
        k0 = longint'(k0_w);
        k1 = longint'(k1_w);
        k2 = longint'(k2_w);
        k3 = longint'(k3_w);
        nn = longint'(n);
        cc = 3 * (k1 - k0);
        cb = 3 * (k0 - 2 * k1 + k2);
        ca = -k0 + 3 * (k1 - k2) + k3;
        den = n * n * n;
        d1 = scaled_quotient(ca + cb * nn + cc * nn * nn, den);
        d2 = scaled_quotient(6 * ca + 2 * cb * nn, den);
        d3 = scaled_quotient(6 * ca, den);
        pos = t_acc'(k0 <<< EXTRA_BITS);
    endfunction

    function automatic void predict_points(input t_segment seg);
        t_acc            pos[NUM_LANES];
        t_acc            d1[NUM_LANES];
        t_acc            d2[NUM_LANES];
        t_acc            d3[NUM_LANES];
        longint unsigned n;
        t_point          p;
        n = (subdiv_cfg == 0) ? 1 : longint'(subdiv_cfg);
        setup_lane(seg.x[0], seg.x[1], seg.x[2], seg.x[3], n, pos[0], d1[0], d2[0], d3[0]);
        setup_lane(seg.y[0], seg.y[1], seg.y[2], seg.y[3], n, pos[1], d1[1], d2[1], d3[1]);
        for (int i = 0; i <= int'(n); i++) begin
            p.x    = pos[0][EXTRA_BITS +: COORD_BITS];
            p.y    = pos[1][EXTRA_BITS +: COORD_BITS];
            p.idx  = SUB_BITS'(i);
            p.last = (i == int'(n));
            pending_points = {pending_points, p};
            for (int l = 0; l < NUM_LANES; l++) begin
                pos[l] = pos[l] + d1[l];
                d1[l]  = d1[l] + d2[l];
                d2[l]  = d2[l] + d3[l];
            end
        end
    endfunction

    function automatic t_segment make_segment(input t_coord x0, input t_coord x1,
                                              input t_coord x2, input t_coord x3,
                                              input t_coord y0, input t_coord y1,
                                              input t_coord y2, input t_coord y3);
        t_segment seg;
        seg.x = '{x0, x1, x2, x3};
        seg.y = '{y0, y1, y2, y3};
        return seg;
    endfunction

    function automatic t_coord rand_coord(input t_coord base);
        case ($urandom_range(0, 7))
            0, 1: return t_coord'($urandom);
            2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            3: return base + t_coord'($urandom_range(0, 255));
            default: return base + (t_coord'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic t_segment rand_segment();
        t_segment seg;
        t_coord   base_x;
        t_coord   base_y;
        base_x = t_coord'($urandom) >>> $urandom_range(0, 16);
        base_y = t_coord'($urandom) >>> $urandom_range(0, 16);
        for (int j = 0; j < NUM_CTRL; j++) begin
            seg.x[j] = rand_coord(base_x);
            seg.y[j] = rand_coord(base_y);
        end
        return seg;
    endfunction

    task automatic send_segment(input t_segment seg);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 6);
        end
        predict_points(seg);
        @(negedge clk);
        in_valid     <= 1'b1;
        start_x      <= seg.x[0];
        handle_out_x <= seg.x[1];
        handle_in_x  <= seg.x[2];
        end_x        <= seg.x[3];
        start_y      <= seg.y[0];
        handle_out_y <= seg.y[1];
        handle_in_y  <= seg.y[2];
        end_y        <= seg.y[3];
        do @(posedge clk); while (in_stall);
        burst_left--;
        if (burst_left == 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 70)
                                                 : $urandom_range(0, 4)) @(negedge clk);
        end
    endtask

    // Holds the input side idle until every queued point has been seen.
    task automatic wait_for_points();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_subdivisions(input logic [SUB_BITS-1:0] value);
        wait_for_points();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        subdiv_cfg = value;
    endtask

    task automatic test_default_subdivisions();
        send_segment(make_segment('0, '0, '0, '0, '0, '0, '0, '0));
        send_segment(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_segment(make_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_segment(make_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                  COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
        send_segment(make_segment('0, ONE, 2 * ONE, 3 * ONE, -ONE, '0, ONE, 2 * ONE));
        send_segment(make_segment(-1, 1, -1, 1, 32'sh0000_8000, -32'sh0000_8000, 3, -3));
    endtask

    task automatic test_single_step();
        write_subdivisions('0);
        send_segment(make_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                                  COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_segment(rand_segment());
        send_segment(make_segment('0, '0, '0, ONE, '0, '0, '0, -ONE));
        write_subdivisions(SUB_BITS'(1));
        send_segment(make_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        send_segment(rand_segment());
        send_segment(rand_segment());
    endtask

    task automatic test_max_subdivisions();
        write_subdivisions(SUB_BITS'(63));
        send_segment(make_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                                  COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
        send_segment(make_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                                  COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_segment(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_segment(rand_segment());
    endtask

    task automatic test_random_segments();
        int plan[11];
        int count;
        plan = '{2, 5, 3, 8, 1, 12, 0, 4, 7, $urandom_range(1, 63), 63};
        foreach (plan[p]) begin
            write_subdivisions(SUB_BITS'(plan[p]));
            count = (plan[p] == 63) ? 6 : 33;
            repeat (count) send_segment(rand_segment());
        end
    endtask

    always @(negedge clk) begin
        if (stall_run == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_run  <= $urandom_range(16, 160);
            out_stall  <= 1'b0;
        end else begin
            stall_run <= stall_run - 1;
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
                default:     out_stall <= (stall_run % 4 != 0);
            endcase
        end
    end

    always @(posedge clk) begin : point_check
        t_point want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_points.size() == 0) begin
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("%0t: unexpected point x=%h y=%h index=%0d last=%b",
                             $realtime, point_x, point_y, point_index, last_point);
                end
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                if (point_x !== want.x || point_y !== want.y ||
                    point_index !== want.idx || last_point !== want.last) begin
                    if (mismatch_count < REPORT_LIMIT) begin
                        $display("%0t: point mismatch, expected x=%h y=%h index=%0d last=%b",
                                 $realtime, want.x, want.y, want.idx, want.last);
                        $display("%0t:                   actual x=%h y=%h index=%0d last=%b",
                                 $realtime, point_x, point_y, point_index, last_point);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        start_x      = '0;
        handle_out_x = '0;
        handle_in_x  = '0;
        end_x        = '0;
        start_y      = '0;
        handle_out_y = '0;
        handle_in_y  = '0;
        end_y        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_subdivisions();
        test_single_step();
        test_max_subdivisions();
        test_random_segments();
        wait_for_points();
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/cbt_pkg.sv
src/cbt_div.sv
src/cbt_lane.sv
src/cubic_bezier_tessellator_unit.sv
dv/tb_top.sv
